@@ rtl/core/nlt_pkg.sv @@
// nlt_pkg: shared sizes, operation and event codes, sequencer state type
// for the node liveness table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nlt_pkg;

    // table size and derived widths
    localparam int NODE_SLOTS = 8;
    localparam int SLOT_W     = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

    // field widths fixed by the interface
    localparam int OP_W      = 2;
    localparam int MESH_W    = 16;
    localparam int HWID_W    = 32;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 27;
    localparam int EVENT_W   = 3;
    localparam int OUT_SLOT_W = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30000);

    // request operation codes
    localparam logic [OP_W-1:0] OP_ANNOUNCE  = 2'd0;
    localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [OP_W-1:0] OP_SWEEP     = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

    // result event codes
    localparam logic [EVENT_W-1:0] EV_ONLINE_FIRST     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_ONLINE_RECOVERED = 3'd1;
    localparam logic [EVENT_W-1:0] EV_ONLINE_REPEAT    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_TABLE_FULL       = 3'd3;
    localparam logic [EVENT_W-1:0] EV_SEEN             = 3'd4;
    localparam logic [EVENT_W-1:0] EV_UNKNOWN          = 3'd5;
    localparam logic [EVENT_W-1:0] EV_OFFLINE          = 3'd6;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SCAN_HW   = 6'b000010,
        ST_ANN_WR    = 6'b000100,
        ST_SCAN_MESH = 6'b001000,
        ST_SWEEP     = 6'b010000,
        ST_SWEEP_END = 6'b100000
    } nlt_state_t;

endpackage

`default_nettype wire

@@ rtl/core/node_liveness_table.sv @@
// node_liveness_table: keepalive table of remote nodes, slot scan sequencer
// with one shared compare / age subtract unit. Depends on nlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  request   | in_valid / in_stall    | op, src_addr, uid, now_time
//  result    | out_valid / out_stall  | event_res, slot, node_addr,
//            |                        | node_uid, any_offline, last
//  config    | cfg_wr_en              | cfg_wr_data (offline_timeout)
//
//  one slot per cycle goes through the shared compare / age-subtract unit, unless a result stall holds the scan
//  announce: accept, scan of up to NODE_SLOTS slots, then the write
//  heartbeat: accept, scan of 1..NODE_SLOTS slots; sweep: accept, scan of
//  all NODE_SLOTS slots, then the summary; result stalls can hold all three
//  in_stall is high while busy; a one-deep output register holds each result
//  reset clears flags, sequencer and out_valid; timeout returns to 30000

module node_liveness_table
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [nlt_pkg::TIMEOUT_W-1:0]      cfg_wr_data,

    // request channel
    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire logic [nlt_pkg::OP_W-1:0]           op,
    input  wire logic [nlt_pkg::MESH_W-1:0]         src_addr,
    input  wire logic [nlt_pkg::HWID_W-1:0]         uid,
    input  wire logic [nlt_pkg::TIME_W-1:0]         now_time,

    // result channel
    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output      logic [nlt_pkg::EVENT_W-1:0]        event_res,
    output      logic [nlt_pkg::OUT_SLOT_W-1:0]     slot,
    output      logic [nlt_pkg::MESH_W-1:0]         node_addr,
    output      logic [nlt_pkg::HWID_W-1:0]         node_uid,
    output      logic                               any_offline,
    output      logic                               last
);

    localparam int N = nlt_pkg::NODE_SLOTS;
    localparam int SW = nlt_pkg::SLOT_W;
    localparam logic [SW-1:0] LAST_IDX = SW'(N - 1);

    // sequencer state
    nlt_pkg::nlt_state_t state_reg, state_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic [SW-1:0]       hit_reg, hit_next;
    logic                free_found_reg, free_found_next;
    logic                new_reg, new_next;
    logic                full_reg, full_next;

    // latched request
    logic [nlt_pkg::MESH_W-1:0] mesh_reg;
    logic [nlt_pkg::HWID_W-1:0] hw_reg;
    logic [nlt_pkg::TIME_W-1:0] now_reg;

    // configuration
    logic [nlt_pkg::TIMEOUT_W-1:0] timeout_reg;

    // slot flags (reset) and slot payload stores (no reset)
    logic [N-1:0] used_reg, used_next;
    logic [N-1:0] online_reg, online_next;
    logic [N-1:0] seen_reg, seen_next;
    logic [nlt_pkg::HWID_W-1:0] hw_mem_reg   [N];
    logic [nlt_pkg::MESH_W-1:0] mesh_mem_reg [N];
    logic [nlt_pkg::TIME_W-1:0] seen_mem_reg [N];

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic [nlt_pkg::EVENT_W-1:0]       ev_reg, ev_next;
    logic [nlt_pkg::OUT_SLOT_W-1:0]    slot_reg, slot_next;
    logic [nlt_pkg::MESH_W-1:0]        omesh_reg, omesh_next;
    logic [nlt_pkg::HWID_W-1:0]        ohw_reg, ohw_next;
    logic                              warn_reg, warn_next;
    logic                              last_reg, last_next;
    logic                              out_load;
    logic                              out_free;

    // store writes
    logic                     ann_we;
    logic                     hb_we;

    // shared unit: one slot read at the scan index
    logic [nlt_pkg::HWID_W-1:0] rd_hw;
    logic [nlt_pkg::MESH_W-1:0] rd_mesh;
    logic [nlt_pkg::TIME_W-1:0] rd_seen;
    logic [nlt_pkg::TIME_W-1:0] age;
    logic                       hw_match;
    logic                       mesh_match;
    logic                       timed_out;
    logic                       accept;

    assign rd_hw      = hw_mem_reg[idx_reg];
    assign rd_mesh    = mesh_mem_reg[idx_reg];
    assign rd_seen    = seen_mem_reg[idx_reg];
    assign age        = now_reg - rd_seen;
    assign hw_match   = used_reg[idx_reg] && (rd_hw == hw_reg);
    assign mesh_match = used_reg[idx_reg] && (rd_mesh == mesh_reg);
    // age compare against the zero-extended timeout, ages wrap modulo 2^32
    assign timed_out  = (age >= {{(nlt_pkg::TIME_W - nlt_pkg::TIMEOUT_W){1'b0}}, timeout_reg});

    assign in_stall = (state_reg != nlt_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // sequencer and result formation
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        new_next        = new_reg;
        full_next       = full_reg;
        used_next       = used_reg;
        online_next     = online_reg;
        seen_next       = seen_reg;
        ann_we          = 1'b0;
        hb_we           = 1'b0;
        out_load        = 1'b0;
        ev_next         = ev_reg;
        slot_next       = slot_reg;
        omesh_next      = omesh_reg;
        ohw_next        = ohw_reg;
        last_next       = last_reg;

        unique case (state_reg)
            nlt_pkg::ST_IDLE:
            begin
                idx_next        = '0;
                free_found_next = 1'b0;
                if (accept)
                begin
                    unique case (op)
                        nlt_pkg::OP_ANNOUNCE:  state_next = nlt_pkg::ST_SCAN_HW;
                        nlt_pkg::OP_HEARTBEAT: state_next = nlt_pkg::ST_SCAN_MESH;
                        nlt_pkg::OP_SWEEP:     state_next = nlt_pkg::ST_SWEEP;
                        default:               state_next = nlt_pkg::ST_IDLE;
                    endcase
                end
            end

            // look for the hardware id, remember the lowest free slot
            nlt_pkg::ST_SCAN_HW:
            begin
                if (hw_match)
                begin
                    hit_next   = idx_reg;
                    new_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = nlt_pkg::ST_ANN_WR;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    new_next   = 1'b1;
                    full_next  = 1'b0;
                    state_next = nlt_pkg::ST_ANN_WR;
                    if (!free_found_reg)
                    begin
                        if (!used_reg[idx_reg])
                            hit_next = idx_reg;
                        else
                            full_next = 1'b1;
                    end
                end
                else
                begin
                    if (!used_reg[idx_reg] && !free_found_reg)
                    begin
                        hit_next        = idx_reg;
                        free_found_next = 1'b1;
                    end
                    idx_next = idx_reg + SW'(1);
                end
            end

            // record the announce and report it, or report a full table
            nlt_pkg::ST_ANN_WR:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    last_next  = 1'b1;
                    omesh_next = mesh_reg;
                    ohw_next   = hw_reg;
                    state_next = nlt_pkg::ST_IDLE;
                    if (full_reg)
                    begin
                        ev_next   = nlt_pkg::EV_TABLE_FULL;
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = nlt_pkg::OUT_SLOT_W'(hit_reg);
                        if (new_reg || !seen_reg[hit_reg])
                            ev_next = nlt_pkg::EV_ONLINE_FIRST;
                        else if (!online_reg[hit_reg])
                            ev_next = nlt_pkg::EV_ONLINE_RECOVERED;
                        else
                            ev_next = nlt_pkg::EV_ONLINE_REPEAT;
                        used_next[hit_reg]   = 1'b1;
                        online_next[hit_reg] = 1'b1;
                        seen_next[hit_reg]   = 1'b1;
                        ann_we               = 1'b1;
                    end
                end
            end

            // refresh the lowest used slot with this mesh address, or report an unknown node
            nlt_pkg::ST_SCAN_MESH:
            begin
                if (out_free)
                begin
                    if (mesh_match)
                    begin
                        out_load             = 1'b1;
                        ev_next              = nlt_pkg::EV_SEEN;
                        slot_next            = nlt_pkg::OUT_SLOT_W'(idx_reg);
                        omesh_next           = rd_mesh;
                        ohw_next             = rd_hw;
                        last_next            = 1'b1;
                        online_next[idx_reg] = 1'b1;
                        seen_next[idx_reg]   = 1'b1;
                        hb_we                = 1'b1;
                        state_next           = nlt_pkg::ST_IDLE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        out_load   = 1'b1;
                        ev_next    = nlt_pkg::EV_UNKNOWN;
                        slot_next  = '0;
                        omesh_next = mesh_reg;
                        ohw_next   = '0;
                        last_next  = 1'b1;
                        state_next = nlt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + SW'(1);
                    end
                end
            end

            // age check of one slot per cycle while the output register is free
            nlt_pkg::ST_SWEEP:
            begin
                if (out_free)
                begin
                    if (used_reg[idx_reg] && online_reg[idx_reg] && timed_out)
                    begin
                        out_load             = 1'b1;
                        ev_next              = nlt_pkg::EV_OFFLINE;
                        slot_next            = nlt_pkg::OUT_SLOT_W'(idx_reg);
                        omesh_next           = rd_mesh;
                        ohw_next             = rd_hw;
                        last_next            = 1'b0;
                        online_next[idx_reg] = 1'b0;
                    end
                    if (idx_reg == LAST_IDX)
                        state_next = nlt_pkg::ST_SWEEP_END;
                    else
                        idx_next = idx_reg + SW'(1);
                end
            end

            nlt_pkg::ST_SWEEP_END:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ev_next    = nlt_pkg::EV_OFFLINE;
                    slot_next  = '0;
                    omesh_next = '0;
                    ohw_next   = '0;
                    last_next  = 1'b1;
                    state_next = nlt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = nlt_pkg::ST_IDLE;
            end
        endcase

        // warning flag taken after the update the result reports
        warn_next = |(used_next & ~online_next);
        if (!out_load)
            warn_next = warn_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nlt_pkg::ST_IDLE;
            idx_reg        <= '0;
            hit_reg        <= '0;
            free_found_reg <= 1'b0;
            new_reg        <= 1'b0;
            full_reg       <= 1'b0;
            used_reg       <= '0;
            online_reg     <= '0;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
            timeout_reg    <= nlt_pkg::TIMEOUT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            new_reg        <= new_next;
            full_reg       <= full_next;
            used_reg       <= used_next;
            online_reg     <= online_next;
            seen_reg       <= seen_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
        end
    end

    // request latch, slot stores and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mesh_reg <= src_addr;
            hw_reg   <= uid;
            now_reg  <= now_time;
        end
        if (ann_we)
        begin
            hw_mem_reg[hit_reg]   <= hw_reg;
            mesh_mem_reg[hit_reg] <= mesh_reg;
            seen_mem_reg[hit_reg] <= now_reg;
        end
        else if (hb_we)
        begin
            seen_mem_reg[idx_reg] <= now_reg;
        end
        if (out_load)
        begin
            ev_reg    <= ev_next;
            slot_reg  <= slot_next;
            omesh_reg <= omesh_next;
            ohw_reg   <= ohw_next;
            warn_reg  <= warn_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = ev_reg;
    assign slot        = slot_reg;
    assign node_addr   = omesh_reg;
    assign node_uid    = ohw_reg;
    assign any_offline = warn_reg;
    assign last        = last_reg;

    // an unused op code is dropped without leaving idle
    a_unused_op_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == nlt_pkg::OP_UNUSED) |=> state_reg == nlt_pkg::ST_IDLE)
        else $error("unused op left the sequencer busy");

    // a node can only be online in a used slot
    a_online_used: assert property (@(posedge clk) disable iff (!rst_n)
        (online_reg & ~used_reg) == '0)
        else $error("online flag set on a free slot");

    // the final result of a request returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && last_next |=> state_reg == nlt_pkg::ST_IDLE)
        else $error("sequencer busy after final result");

    // a result is loaded only when the output register can take it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !out_load)
        else $error("pending result overwritten");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

`default_nettype wire
